// ===== sv/fdc_pkg.sv =====
// shared types and constants for the freezer defrost controller
package fdc_pkg;

  localparam int TEMP_WIDTH   = 16;
  localparam int TIME_WIDTH   = 24;
  localparam int UPTIME_WIDTH = 32;
  // tick counters need one bit above the limit registers
  localparam int CNT_WIDTH    = TIME_WIDTH + 1;
  localparam int REG_IDX_WIDTH = 2;

  typedef enum logic [1:0] {
    MODE_WAIT    = 2'd0,
    MODE_FREEZE  = 2'd1,
    MODE_DEFROST = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    DRIVE_OFF  = 2'd0,
    DRIVE_COMP = 2'd1,
    DRIVE_HEAT = 2'd2
  } drive_t;

  typedef enum logic [1:0] {
    STATUS_STANDBY  = 2'd0,
    STATUS_FREEZING = 2'd1,
    STATUS_HEATING  = 2'd2
  } status_t;

  typedef enum logic [REG_IDX_WIDTH-1:0] {
    REG_STARTUP_WAIT = 2'd0,
    REG_MAX_FREEZE   = 2'd1,
    REG_DRIP_WAIT    = 2'd2,
    REG_MAX_DEFROST  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [UPTIME_WIDTH-1:0]      uptime_seconds;
    logic signed [TEMP_WIDTH-1:0] freezer_temp;
    logic                         freezer_temp_ok;
    logic signed [TEMP_WIDTH-1:0] cooler_temp;
    logic                         cooler_temp_ok;
    logic signed [TEMP_WIDTH-1:0] freezer_target;
    logic signed [TEMP_WIDTH-1:0] cooler_target;
    logic                         relay_open;
  } fdc_in_t;

  typedef struct packed {
    logic       fan_open;
    logic [1:0] drive;
    logic [1:0] status;
  } fdc_out_t;

  typedef struct packed {
    logic [TIME_WIDTH-1:0] startup_wait_sec;
    logic [TIME_WIDTH-1:0] max_freeze_sec;
    logic [TIME_WIDTH-1:0] drip_wait_sec;
    logic [TIME_WIDTH-1:0] max_defrost_sec;
  } fdc_cfg_t;

  typedef struct packed {
    mode_t                mode;
    logic [CNT_WIDTH-1:0] freeze_ticks;
    logic [CNT_WIDTH-1:0] defrost_ticks;
    logic [CNT_WIDTH-1:0] drip_ticks;
    logic                 relay_seen_open;
    logic                 fan_state;
    drive_t               drive_state;
  } fdc_state_t;

endpackage

// ===== sv/fdc_cfg.sv =====
// configuration register file for the freezer defrost controller
module fdc_cfg
  import fdc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [REG_IDX_WIDTH-1:0] cfg_index,
  input  logic [TIME_WIDTH-1:0]    cfg_data,
  output fdc_cfg_t                 cfg
);

  reg_idx_t idx;

  // writes are always taken
  assign cfg_ready = 1'b1;
  assign idx       = reg_idx_t'(cfg_index);

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (idx)
        REG_STARTUP_WAIT: cfg.startup_wait_sec <= cfg_data;
        REG_MAX_FREEZE:   cfg.max_freeze_sec   <= cfg_data;
        REG_DRIP_WAIT:    cfg.drip_wait_sec    <= cfg_data;
        REG_MAX_DEFROST:  cfg.max_defrost_sec  <= cfg_data;
      endcase
    end
  end

endmodule

// ===== sv/fdc_step.sv =====
// next-state and result logic for one tick of the defrost controller
module fdc_step
  import fdc_pkg::*;
(
  input  fdc_in_t    req,
  input  fdc_cfg_t   cfg,
  input  fdc_state_t state,
  output fdc_state_t state_next,
  output fdc_out_t   result
);

  logic [CNT_WIDTH-1:0] freeze_inc;
  logic [CNT_WIDTH-1:0] defrost_inc;
  logic [CNT_WIDTH-1:0] drip_new;
  logic [CNT_WIDTH-1:0] heat_limit;
  logic                 both_cold;
  status_t              status;

  // counter increments and comparisons against the limit registers
  assign freeze_inc  = CNT_WIDTH'(state.freeze_ticks + 1'b1);
  assign defrost_inc = CNT_WIDTH'(state.defrost_ticks + 1'b1);
  assign heat_limit  = CNT_WIDTH'(cfg.max_defrost_sec >> 1);
  assign both_cold   = (req.freezer_temp < req.freezer_target) &&
                       (req.cooler_temp < req.cooler_target);

  // mode sequencing
  always_comb begin
    state_next = state;
    drip_new   = state.drip_ticks;
    status     = STATUS_STANDBY;
    unique case (state.mode)
      MODE_WAIT: begin
        if (UPTIME_WIDTH'(cfg.startup_wait_sec) < req.uptime_seconds) begin
          state_next.mode = MODE_FREEZE;
        end
        state_next.fan_state   = 1'b1;
        state_next.drive_state = DRIVE_OFF;
        status                 = STATUS_STANDBY;
      end
      MODE_FREEZE: begin
        // actuators only move on reliable readings
        if (req.freezer_temp_ok && req.cooler_temp_ok) begin
          if (both_cold) begin
            state_next.fan_state   = 1'b1;
            state_next.drive_state = DRIVE_OFF;
            state_next.mode        = MODE_WAIT;
          end else begin
            state_next.fan_state   = 1'b0;
            state_next.drive_state = DRIVE_COMP;
          end
        end
        // cumulative freezing time forces a defrost
        if (CNT_WIDTH'(cfg.max_freeze_sec) < freeze_inc) begin
          state_next.freeze_ticks = '0;
          state_next.mode         = MODE_DEFROST;
        end else begin
          state_next.freeze_ticks = freeze_inc;
        end
        status = STATUS_FREEZING;
      end
      default: begin
        // defrost: heater until relay opens or half the limit; drip time runs once the relay opens
        if (req.relay_open || state.relay_seen_open) begin
          state_next.relay_seen_open = 1'b1;
          drip_new                   = CNT_WIDTH'(state.drip_ticks + 1'b1);
          state_next.drive_state     = DRIVE_OFF;
        end else if (defrost_inc < heat_limit) begin
          state_next.drive_state = DRIVE_HEAT;
        end else begin
          state_next.drive_state = DRIVE_OFF;
        end
        if ((CNT_WIDTH'(cfg.drip_wait_sec) < drip_new) ||
            (CNT_WIDTH'(cfg.max_defrost_sec) < defrost_inc)) begin
          state_next.defrost_ticks   = '0;
          state_next.drip_ticks      = '0;
          state_next.relay_seen_open = 1'b0;
          state_next.mode            = MODE_FREEZE;
        end else begin
          state_next.defrost_ticks = defrost_inc;
          state_next.drip_ticks    = drip_new;
        end
        status = STATUS_HEATING;
      end
    endcase
  end

  // result carries the held actuator state
  assign result.fan_open = state_next.fan_state;
  assign result.drive    = state_next.drive_state;
  assign result.status   = status;

endmodule

// ===== sv/freezer_defrost_controller.sv =====
// top level of the freezer defrost controller: request stage, state and result register
//
//   channel  direction  handshake           payload
//   in       sink       in_valid/in_stall   in_data   (fdc_in_t, one tick)
//   out      source     out_valid/out_stall out_data  (fdc_out_t, one result per tick)
//   cfg      sink       cfg_valid/cfg_ready cfg_index, cfg_data (four limit registers)
//
// a request is registered, then the step logic updates the mode state and loads the
// result register; one request per cycle is sustained while out_stall is low.
// the rate is set by the combinational step path from the request register to the result register.
// rst is synchronous; it clears the limit registers, mode state and both valid flags.
// out_stall holds the result register; a request waiting behind it raises in_stall.
// cfg_ready is always high.
module freezer_defrost_controller
  import fdc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  fdc_in_t                  in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output fdc_out_t                 out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [REG_IDX_WIDTH-1:0] cfg_index,
  input  logic [TIME_WIDTH-1:0]    cfg_data
);

  fdc_cfg_t   cfg;
  fdc_state_t state;
  fdc_state_t state_next;
  fdc_out_t   result;
  fdc_in_t    req;
  logic       req_valid;
  logic       req_advance;
  logic       in_accept;

  // limit registers
  fdc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // per-tick logic
  fdc_step u_step (
    .req        (req),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  // handshake between request stage and result register
  assign req_advance = req_valid && (!out_valid || !out_stall);
  assign in_stall    = req_valid && !req_advance;
  assign in_accept   = in_valid && !in_stall;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_accept) begin
      req_valid <= 1'b1;
    end else if (req_advance) begin
      req_valid <= 1'b0;
    end
    if (in_accept) begin
      req <= in_data;
    end
  end

  // controller state, updated once per request
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode            <= MODE_WAIT;
      state.freeze_ticks    <= '0;
      state.defrost_ticks   <= '0;
      state.drip_ticks      <= '0;
      state.relay_seen_open <= 1'b0;
      state.fan_state       <= 1'b1;
      state.drive_state     <= DRIVE_OFF;
    end else if (req_advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (req_advance) begin
      out_data <= result;
    end
  end

  // heater is never left on outside defrost
  assert property (@(posedge clk) disable iff (rst)
    (state.drive_state == DRIVE_HEAT) |-> (state.mode == MODE_DEFROST))
    else $error("heater held outside defrost");

  // relay latch is only set during defrost
  assert property (@(posedge clk) disable iff (rst)
    state.relay_seen_open |-> (state.mode == MODE_DEFROST))
    else $error("relay latch set outside defrost");

  // drip time only runs once the relay has been seen open
  assert property (@(posedge clk) disable iff (rst)
    (state.drip_ticks != '0) |-> state.relay_seen_open)
    else $error("drip counter running without relay latch");

  // a request leaving the request stage always lands in the result register
  assert property (@(posedge clk) disable iff (rst)
    req_advance |=> out_valid)
    else $error("request lost between stages");

endmodule
